// ===== hdl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants for the first-fit heap allocator
// Block table entry layout, sequencer states and result status codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int unsigned POOL_BYTES = 1024;
    localparam int unsigned MAX_BLOCKS = 32;
    localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned POS_W      = 11;
    localparam int unsigned SIZE_W     = 11;
    localparam int unsigned HDR_W      = 7;
    localparam logic [HDR_W-1:0] HDR_RESET = 7'd24;

    localparam logic [2:0] ST_ALLOC_WHOLE = 3'd0;
    localparam logic [2:0] ST_ALLOC_SPLIT = 3'd1;
    localparam logic [2:0] ST_NO_FIT      = 3'd2;
    localparam logic [2:0] ST_FREED       = 3'd3;
    localparam logic [2:0] ST_NULL        = 3'd4;
    localparam logic [2:0] ST_NO_BLOCK    = 3'd5;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_FREE_SCAN,
        S_MERGE_LOAD,
        S_MERGE_STEP
    } state_t;

endpackage

// ===== hdl/first_fit_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core: first-fit allocator with split and coalesce
// Walks an address-ordered block table one entry per cycle.
// ----------------------------------------------------------------------------
// Sequence: allocate scans from entry 0 until a free block fits (at most 32
//   blocks visited); free scans for the matching block, then walks the
//   table from entry 0 merging free neighbors. A null free ends in idle.
// Throughput: one word at a time; busy stays high for the whole walk, set
//   by the single table read port walked by the sequencer.
// Result: done pulses one cycle; the receiver cannot stall.
// Reset: header 24, one free block covering the pool; a header write
//   rebuilds that layout at once.
module first_fit_heap_allocator_core
    import ffha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              mode,
    input  logic [10:0]       request_size,
    input  logic [9:0]        free_offset,
    input  logic              cfg_we,
    input  logic [HDR_W-1:0]  cfg_data,
    output logic              done,
    output logic [2:0]        status,
    output logic [9:0]        data_offset,
    output logic [4:0]        merge_count
);

    state_t            state_reg, state_next;
    entry_t            tbl_reg [MAX_BLOCKS];
    logic [CNT_W-1:0]  count_reg;
    logic [HDR_W-1:0]  hdr_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    entry_t            cur_reg, cur_next;
    logic [10:0]       req_reg;
    logic [9:0]        off_reg;
    logic [4:0]        merges_reg, merges_next;
    logic              done_reg, done_next;
    logic [2:0]        status_reg, status_next;
    logic [9:0]        data_reg, data_next;

    // Table update controls
    logic              tbl_we, tbl_ins, tbl_rem;
    entry_t            tbl_wd, tbl_nd;

    logic [CNT_W-1:0]  rd_idx;
    entry_t            rd_e;
    logic              rd_ok;
    logic [11:0]       data_pos;
    logic [11:0]       req_hdr;
    logic [11:0]       split_pos;
    logic [11:0]       merged;
    logic [11:0]       rest;

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign data_offset = data_reg;
    assign merge_count = merges_reg;

    // Merge walk reads the neighbor after the cursor; scans read the cursor.
    assign rd_idx    = (state_reg == S_MERGE_STEP) ? idx_reg + 1'b1 : idx_reg;
    assign rd_ok     = (rd_idx < count_reg);
    assign rd_e      = tbl_reg[rd_idx[IDX_W-1:0]];
    assign data_pos  = {1'b0, rd_e.pos} + {5'd0, hdr_reg};
    assign req_hdr   = {1'b0, req_reg} + {5'd0, hdr_reg};
    assign split_pos = data_pos + {1'b0, req_reg};
    assign rest      = {1'b0, rd_e.size} - req_hdr;
    assign merged    = {1'b0, cur_reg.size} + {5'd0, hdr_reg} + {1'b0, rd_e.size};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        merges_next = merges_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        tbl_we      = 1'b0;
        tbl_ins     = 1'b0;
        tbl_rem     = 1'b0;
        tbl_wd      = rd_e;
        tbl_nd      = rd_e;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    merges_next = '0;
                    data_next   = '0;
                    if (mode == MODE_ALLOC)
                    begin
                        state_next = S_ALLOC_SCAN;
                    end
                    else if (free_offset == 10'd0)
                    begin
                        // drop a null free at once
                        status_next = ST_NULL;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FREE_SCAN;
                    end
                end
            end
            S_ALLOC_SCAN:
            begin
                if (!rd_ok)
                begin
                    status_next = ST_NO_FIT;
                    data_next   = '0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (rd_e.free && (rd_e.size >= req_reg))
                begin
                    data_next = data_pos[9:0];
                    tbl_we    = 1'b1;
                    tbl_wd    = rd_e;
                    tbl_wd.free = 1'b0;
                    if (({1'b0, rd_e.size} > req_hdr) && (count_reg < CNT_W'(MAX_BLOCKS)))
                    begin
                        tbl_ins     = 1'b1;
                        tbl_wd.size = req_reg;
                        tbl_nd.pos  = split_pos[POS_W-1:0];
                        tbl_nd.size = rest[SIZE_W-1:0];
                        tbl_nd.free = 1'b1;
                        status_next = ST_ALLOC_SPLIT;
                    end
                    else
                    begin
                        status_next = ST_ALLOC_WHOLE;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FREE_SCAN:
            begin
                if (!rd_ok)
                begin
                    status_next = ST_NO_BLOCK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (data_pos == {2'b00, off_reg})
                begin
                    tbl_we      = 1'b1;
                    tbl_wd      = rd_e;
                    tbl_wd.free = 1'b1;
                    idx_next    = '0;
                    state_next  = S_MERGE_LOAD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_MERGE_LOAD:
            begin
                cur_next   = rd_e;
                state_next = S_MERGE_STEP;
            end
            S_MERGE_STEP:
            begin
                if (!rd_ok)
                begin
                    status_next = ST_FREED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (cur_reg.free && rd_e.free)
                begin
                    // fold the neighbor in and recheck the same cursor
                    cur_next.size = merged[SIZE_W-1:0];
                    tbl_we        = 1'b1;
                    tbl_wd        = cur_next;
                    tbl_rem       = 1'b1;
                    if (merges_reg != 5'd31)
                    begin
                        merges_next = merges_reg + 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    cur_next = rd_e;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            idx_reg    <= '0;
            merges_reg <= '0;
            status_reg <= '0;
            data_reg   <= '0;
        end
        else
        begin
            done_reg   <= done_next;
            idx_reg    <= idx_next;
            merges_reg <= merges_next;
            status_reg <= status_next;
            data_reg   <= data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (start && !busy)
        begin
            req_reg  <= request_size;
            off_reg  <= free_offset;
        end
    end

    // Block table: entries above the cursor shift on insert or remove, one write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg         <= HDR_RESET;
            count_reg       <= CNT_W'(1);
            tbl_reg[0].pos  <= '0;
            tbl_reg[0].size <= SIZE_W'(POOL_BYTES - HDR_RESET);
            tbl_reg[0].free <= 1'b1;
        end
        else if (cfg_we)
        begin
            hdr_reg         <= cfg_data;
            count_reg       <= CNT_W'(1);
            tbl_reg[0].pos  <= '0;
            tbl_reg[0].size <= SIZE_W'(POOL_BYTES) - {4'd0, cfg_data};
            tbl_reg[0].free <= 1'b1;
        end
        else
        begin
            for (int j = 0; j < MAX_BLOCKS; j++)
            begin
                if (tbl_ins && (j > idx_reg + 1) && (j >= 1))
                begin
                    tbl_reg[j] <= tbl_reg[(j >= 1) ? j - 1 : 0];
                end
                if (tbl_ins && (j == idx_reg + 1))
                begin
                    tbl_reg[j] <= tbl_nd;
                end
                if (tbl_rem && (j >= idx_reg + 1) && (j < MAX_BLOCKS - 1))
                begin
                    tbl_reg[j] <= tbl_reg[(j < MAX_BLOCKS - 1) ? j + 1 : j];
                end
                if (tbl_we && (j == idx_reg))
                begin
                    tbl_reg[j] <= tbl_wd;
                end
            end
            if (tbl_ins)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (tbl_rem)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_W'(MAX_BLOCKS)))
        else $error("block count out of range");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ST_NO_BLOCK))
        else $error("bad status code");

    a_merge_only_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (merge_count != 5'd0)) |-> (status == ST_FREED))
        else $error("merges reported on non-free result");

endmodule
